// ----- rtl/rc6_pkg.sv -----
// ----------------------------------------------------------------------------
// RC6 cipher core package
// Shared types and constants for the cipher core.
// ----------------------------------------------------------------------------
package rc6_pkg;

    localparam logic [31:0] SEED_P = 32'hb7e15163;
    localparam logic [31:0] SEED_Q = 32'h9e3779b9;

    typedef enum logic [1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ENCRYPT = 2'd1,
        ACT_DECRYPT = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEED,
        ST_MIX_RD,
        ST_MIX_WR,
        ST_PRE_RD0,
        ST_PRE_RD1,
        ST_PRE_ADD,
        ST_RND_RD0,
        ST_RND_RD1,
        ST_RND_EXE,
        ST_POST_RD0,
        ST_POST_RD1,
        ST_POST_ADD,
        ST_OUT
    } state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

endpackage

// ----- rtl/rc6_variant_block_cipher_core.sv -----
// ----------------------------------------------------------------------------
// RC6-style block cipher core
// Key load: a load marked last starts the key expansion, which stalls the input
//   through the seeding and then 3*max(KEY_WORDS,2*ROUNDS+4) mix steps, each a
//   read state and a write state.
// Block: the input stalls from acceptance until the result is handed to the
//   output register, so one block is in flight at a time; one shared round unit,
//   each round reading its two round keys one at a time from the single-port key memory.
// rst_n clears control, output valid and user_key; memories are not cleared.
// ----------------------------------------------------------------------------
module rc6_variant_block_cipher_core
    import rc6_pkg::*;
#(
    parameter int ROUNDS    = 40,
    parameter int KEY_WORDS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [2:0]  key_index,
    input  logic [31:0] key_word,
    input  logic        key_last,
    input  logic [31:0] in_word0,
    input  logic [31:0] in_word1,
    input  logic [31:0] in_word2,
    input  logic [31:0] in_word3,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_word0,
    output logic [31:0] out_word1,
    output logic [31:0] out_word2,
    output logic [31:0] out_word3,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int TW       = 2 * ROUNDS + 4;
    localparam int MIX      = 3 * ((KEY_WORDS > TW) ? KEY_WORDS : TW);
    // seeding also copies the key words, one a cycle, each in the cycle after its read
    localparam int SEED_LEN = (TW > KEY_WORDS) ? TW : KEY_WORDS + 1;
    localparam int SW       = $clog2(TW);
    localparam int KW       = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
    localparam int MW       = $clog2(MIX + 1);
    localparam int RW       = $clog2(ROUNDS + 1);

    // Round key store and key word store, synchronous read.
    logic [31:0] rk_mem [TW];
    logic [31:0] kw_mem [KEY_WORDS];
    // Working copy of the key words for the expansion.
    logic [31:0] work_reg [KEY_WORDS];

    state_t      state_reg, state_next;
    logic [31:0] user_key_reg;
    logic        dec_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] k0_reg, t_reg, u_reg;
    logic [31:0] ea_reg, eb_reg, rd_rk_reg, kw_rd_reg;
    logic [SW-1:0] s_reg;
    logic [KW-1:0] w_reg;
    logic [MW-1:0] step_reg;
    logic [RW-1:0] rnd_reg;
    logic [31:0] seed_reg;
    logic        out_valid_reg;
    logic [31:0] out_word0_reg, out_word1_reg, out_word2_reg, out_word3_reg;

    logic        rk_we, kw_we;
    logic [SW-1:0] rk_addr;
    logic [KW-1:0] kw_addr;
    logic [31:0] rk_wd;
    logic        acc, out_load;
    logic [31:0] work_rd, na, nb, sum_ab;
    logic [31:0] mix_b, mix_d, mt, mu;
    logic [31:0] qb, qd, pa, pc;
    logic [SW-1:0] rk_even;

    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = (state_reg == ST_IDLE);
    assign acc       = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word0 = out_word0_reg;
    assign out_word1 = out_word1_reg;
    assign out_word2 = out_word2_reg;
    assign out_word3 = out_word3_reg;

    // Hand the block to the output register once it is free or being emptied
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // round key index for this round: 2r (A) then 2r+1 (C)
    assign rk_even = SW'({rnd_reg, 1'b0});

    // Mix step arithmetic
    assign work_rd = work_reg[w_reg];
    assign na      = rotl(rd_rk_reg + ea_reg + eb_reg, 5'd3);
    assign sum_ab  = na + eb_reg;
    assign nb      = rotl(work_rd + sum_ab, sum_ab[4:0]);

    // Round mixers: encrypt squares B and D, decrypt the words that rotate into them
    assign mix_b = dec_reg ? a_reg : b_reg;
    assign mix_d = dec_reg ? c_reg : d_reg;
    assign mt    = rotl(mix_b * {mix_b[30:0], 1'b1}, 5'd5);
    assign mu    = rotl(mix_d * {mix_d[30:0], 1'b1}, 5'd5);

    // Forward round: k0 holds key 2r, the read register key 2r+1
    assign qb = rotl(c_reg ^ u_reg, t_reg[4:0]) + rd_rk_reg;
    assign qd = rotl(a_reg ^ t_reg, u_reg[4:0]) + k0_reg;
    // Inverse round, with the word rotation folded in
    assign pa = rotr(d_reg - k0_reg, u_reg[4:0]) ^ t_reg;
    assign pc = rotr(b_reg - rd_rk_reg, t_reg[4:0]) ^ u_reg;

    always_comb
    begin
        rk_we   = 1'b0;
        kw_we   = 1'b0;
        rk_addr = s_reg;
        kw_addr = '0;
        rk_wd   = seed_reg;
        case (state_reg)
            ST_IDLE:
            begin
                kw_addr = KW'(key_index);
                kw_we   = acc && (action == ACT_LOAD) &&
                          (32'(key_index) < 32'(KEY_WORDS));
            end
            ST_SEED:
            begin
                rk_addr = SW'(step_reg);
                rk_we   = (32'(step_reg) < 32'(TW));
                if (32'(step_reg) < 32'(KEY_WORDS))
                    kw_addr = KW'(step_reg);
            end
            ST_MIX_WR:
            begin
                rk_we = 1'b1;
                rk_wd = na;
            end
            ST_PRE_RD0:  rk_addr = dec_reg ? SW'(TW - 2) : '0;
            ST_PRE_RD1:  rk_addr = dec_reg ? SW'(TW - 1) : SW'(1);
            ST_RND_RD0:  rk_addr = rk_even;
            ST_RND_RD1:  rk_addr = rk_even + SW'(1);
            ST_POST_RD0: rk_addr = dec_reg ? '0 : SW'(TW - 2);
            ST_POST_RD1: rk_addr = dec_reg ? SW'(1) : SW'(TW - 1);
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
            rk_mem[rk_addr] <= rk_wd;
        rd_rk_reg <= rk_mem[rk_addr];
    end

    always_ff @(posedge clk)
    begin
        if (kw_we)
            kw_mem[kw_addr] <= key_word;
        kw_rd_reg <= kw_mem[kw_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (acc)
                begin
                    if (action == ACT_LOAD && key_last)       state_next = ST_SEED;
                    else if (action == ACT_ENCRYPT ||
                             action == ACT_DECRYPT)           state_next = ST_PRE_RD0;
                end
            ST_SEED:     if (step_reg == MW'(SEED_LEN - 1)) state_next = ST_MIX_RD;
            ST_MIX_RD:   state_next = ST_MIX_WR;
            ST_MIX_WR:   state_next = (step_reg == MW'(MIX - 1)) ? ST_IDLE : ST_MIX_RD;
            ST_PRE_RD0:  state_next = ST_PRE_RD1;
            ST_PRE_RD1:  state_next = ST_PRE_ADD;
            ST_PRE_ADD:  state_next = ST_RND_RD0;
            ST_RND_RD0:  state_next = ST_RND_RD1;
            ST_RND_RD1:  state_next = ST_RND_EXE;
            ST_RND_EXE:
                if ((!dec_reg && rnd_reg == RW'(ROUNDS)) || (dec_reg && rnd_reg == RW'(1)))
                    state_next = ST_POST_RD0;
                else
                    state_next = ST_RND_RD0;
            ST_POST_RD0: state_next = ST_POST_RD1;
            ST_POST_RD1: state_next = ST_POST_ADD;
            ST_POST_ADD: state_next = ST_OUT;
            ST_OUT:      if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            user_key_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                user_key_reg <= cfg_data;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register (no reset)
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word0_reg <= a_reg;
            out_word1_reg <= b_reg;
            out_word2_reg <= c_reg;
            out_word3_reg <= d_reg;
        end
    end

    // Datapath registers (no reset)
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                s_reg    <= '0;
                w_reg    <= '0;
                step_reg <= '0;
                seed_reg <= SEED_P;
                ea_reg   <= '0;
                eb_reg   <= '0;
                dec_reg  <= (action == ACT_DECRYPT);
                rnd_reg  <= (action == ACT_DECRYPT) ? RW'(ROUNDS) : RW'(1);
                if (action == ACT_DECRYPT)
                begin
                    a_reg <= in_word0 ^ user_key_reg;
                    b_reg <= in_word1 ^ user_key_reg;
                    c_reg <= in_word2 ^ user_key_reg;
                    d_reg <= in_word3 ^ user_key_reg;
                end
                else
                begin
                    a_reg <= in_word0;
                    b_reg <= in_word1;
                    c_reg <= in_word2;
                    d_reg <= in_word3;
                end
            end
            ST_SEED:
            begin
                seed_reg <= seed_reg + SEED_Q;
                step_reg <= (step_reg == MW'(SEED_LEN - 1)) ? '0 : step_reg + MW'(1);
                // key word read last cycle lands in the working copy
                if (32'(step_reg) >= 32'd1 && 32'(step_reg) <= 32'(KEY_WORDS))
                    work_reg[KW'(32'(step_reg) - 32'd1)] <= kw_rd_reg;
            end
            ST_MIX_WR:
            begin
                ea_reg   <= na;
                eb_reg   <= nb;
                work_reg[w_reg] <= nb;
                s_reg    <= (s_reg == SW'(TW - 1)) ? '0 : s_reg + SW'(1);
                w_reg    <= (32'(w_reg) == 32'(KEY_WORDS - 1)) ? '0 : w_reg + KW'(1);
                step_reg <= step_reg + MW'(1);
            end
            ST_PRE_RD1: k0_reg <= rd_rk_reg;
            ST_PRE_ADD:
            begin
                if (dec_reg)
                begin
                    a_reg <= a_reg - k0_reg;
                    c_reg <= c_reg - rd_rk_reg;
                end
                else
                begin
                    b_reg <= b_reg + k0_reg;
                    d_reg <= d_reg + rd_rk_reg;
                end
            end
            ST_RND_RD0:
            begin
                t_reg <= mt;
                u_reg <= mu;
            end
            ST_RND_RD1: k0_reg <= rd_rk_reg;
            ST_RND_EXE:
            begin
                if (!dec_reg)
                begin
                    a_reg   <= b_reg;
                    b_reg   <= qb;
                    c_reg   <= d_reg;
                    d_reg   <= qd;
                    rnd_reg <= rnd_reg + RW'(1);
                end
                else
                begin
                    a_reg   <= pa;
                    b_reg   <= a_reg;
                    c_reg   <= pc;
                    d_reg   <= c_reg;
                    rnd_reg <= rnd_reg - RW'(1);
                end
            end
            ST_POST_RD1: k0_reg <= rd_rk_reg;
            ST_POST_ADD:
            begin
                if (dec_reg)
                begin
                    b_reg <= b_reg - k0_reg;
                    d_reg <= d_reg - rd_rk_reg;
                end
                else
                begin
                    a_reg <= (a_reg + k0_reg) ^ user_key_reg;
                    b_reg <= b_reg ^ user_key_reg;
                    c_reg <= (c_reg + rd_rk_reg) ^ user_key_reg;
                    d_reg <= d_reg ^ user_key_reg;
                end
            end
            default: ;
        endcase
    end

    // Result payload holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable({out_word3, out_word2, out_word1, out_word0}));

    // Configuration only taken while idle
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !in_stall);

    // Round counter within range while a round executes
    a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND_EXE) |-> (rnd_reg >= RW'(1)) && (rnd_reg <= RW'(ROUNDS)));

    // Control state always known
    a_state_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown(state_reg));

endmodule

// ----- tb/rc6_variant_block_cipher_core_test.sv -----
// ----------------------------------------------------------------------------
// RC6-style block cipher core testbench
// Loads key words, expands keys and runs encrypt/decrypt blocks under
// several whitening masks. Results are predicted in the bench and compared
// word by word, with random idle bursts on both the input and the output side.
// ----------------------------------------------------------------------------
class cipher_scoreboard;
    logic [31:0] rkeys[84];
    logic [31:0] kwords[8];
    logic [31:0] mask;
    logic [127:0] pending[$];
    int errors;

    function new();
        mask = 0;
        errors = 0;
        foreach (rkeys[i]) rkeys[i] = 0;
        foreach (kwords[i]) kwords[i] = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        if (s == 0) return x;
        return (x << s) | (x >> (6'd32 - s));
    endfunction

    function logic [31:0] ror(logic [31:0] x, logic [31:0] n);
        logic [4:0] s;
        s = n[4:0];
        if (s == 0) return x;
        return (x >> s) | (x << (6'd32 - s));
    endfunction

    function logic [31:0] quad(logic [31:0] x);
        return rol(x * (2 * x + 1), 5);
    endfunction

    function void expand();
        logic [31:0] work[8];
        logic [31:0] a, b;
        int s, w;
        a = 0;
        b = 0;
        s = 0;
        w = 0;
        work = kwords;
        rkeys[0] = rc6_pkg::SEED_P;
        for (int i = 1; i < 84; i++) rkeys[i] = rkeys[i-1] + rc6_pkg::SEED_Q;
        for (int i = 0; i < 252; i++)
        begin
            rkeys[s] = rol(rkeys[s] + a + b, 3);
            a = rkeys[s];
            work[w] = rol(work[w] + a + b, a + b);
            b = work[w];
            s = (s + 1) % 84;
            w = (w + 1) % 8;
        end
    endfunction

    // Note one accepted input transaction and queue its expected block.
    function void note_input(rc6_pkg::action_t act, logic [2:0] idx, logic [31:0] kw,
                             logic klast, logic [127:0] blk);
        logic [31:0] a, b, c, d, t, u, x;
        a = blk[31:0];
        b = blk[63:32];
        c = blk[95:64];
        d = blk[127:96];
        case (act)
            rc6_pkg::ACT_LOAD:
            begin
                kwords[idx] = kw;
                if (klast) expand();
            end
            rc6_pkg::ACT_ENCRYPT:
            begin
                b += rkeys[0];
                d += rkeys[1];
                for (int r = 1; r <= 40; r++)
                begin
                    t = quad(b);
                    u = quad(d);
                    a = rol(a ^ t, u) + rkeys[2*r];
                    c = rol(c ^ u, t) + rkeys[2*r+1];
                    x = a; a = b; b = c; c = d; d = x;
                end
                a = (a + rkeys[82]) ^ mask;
                b ^= mask;
                c = (c + rkeys[83]) ^ mask;
                d ^= mask;
                pending.push_back({d, c, b, a});
            end
            rc6_pkg::ACT_DECRYPT:
            begin
                a = (a ^ mask) - rkeys[82];
                b ^= mask;
                c = (c ^ mask) - rkeys[83];
                d ^= mask;
                for (int r = 40; r >= 1; r--)
                begin
                    x = d; d = c; c = b; b = a; a = x;
                    u = quad(d);
                    t = quad(b);
                    c = ror(c - rkeys[2*r+1], t) ^ u;
                    a = ror(a - rkeys[2*r], u) ^ t;
                end
                b -= rkeys[0];
                d -= rkeys[1];
                pending.push_back({d, c, b, a});
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [127:0] got);
        logic [127:0] exp;
        if (pending.size() == 0)
        begin
            $error("unexpected result block %h", got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        for (int i = 0; i < 4; i++)
            if (exp[32*i +: 32] !== got[32*i +: 32])
            begin
                $error("out_word%0d: expected %h, got %h", i, exp[32*i +: 32], got[32*i +: 32]);
                errors++;
            end
    endfunction
endclass

module rc6_variant_block_cipher_core_test;
    import rc6_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [2:0]  key_index;
    logic [31:0] key_word;
    logic        key_last;
    logic [31:0] in_word0, in_word1, in_word2, in_word3;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] out_word0, out_word1, out_word2, out_word3;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    cipher_scoreboard board;
    bit  quiet_tail;      // no idling in the closing stretch
    int  idle_cycles;     // watchdog: cycles with no transaction
    localparam int WATCHDOG = 4000;  // covers a key expansion plus the longest output stall burst

    rc6_variant_block_cipher_core dut (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Result side: random stall bursts, checked at the rising edge.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!quiet_tail && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result({out_word3, out_word2, out_word1, out_word0});

    // Watchdog on transaction progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Present one transaction and hold it until accepted; valid stays up
    // for a following send, idle bursts and drain drop it.
    task automatic send(action_t act, logic [2:0] idx, logic [31:0] kw, logic klast,
                        logic [127:0] blk);
        if (!quiet_tail && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        key_index <= idx;
        key_word  <= kw;
        key_last  <= klast;
        {in_word3, in_word2, in_word1, in_word0} <= blk;
        do @(posedge clk); while (in_stall);
        board.note_input(act, idx, kw, klast, blk);
        @(negedge clk);
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Wait for all results; loads may still be expanding, so allow a margin.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_mask(logic [31:0] m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        do @(posedge clk); while (!cfg_ready);
        board.mask = m;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Full key: eight words, the last marked to start expansion.
    task automatic load_key(bit extreme);
        logic [31:0] w;
        for (int i = 0; i < 8; i++)
        begin
            w = extreme ? ((i % 2) ? 32'hffffffff : 32'h0) : $urandom;
            send(ACT_LOAD, i[2:0], w, i == 7, rand_block());
        end
    endtask

    logic [31:0] masks[4];

    initial
    begin
        board = new();
        quiet_tail = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = ACT_LOAD;
        key_index = '0;
        key_word = '0;
        key_last = 1'b0;
        {in_word3, in_word2, in_word1, in_word0} = 128'h0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extreme key, extreme blocks, both directions, unused action.
        write_mask(32'h0);
        load_key(1);
        send(ACT_ENCRYPT, 3'd0, 32'd0, 1'b0, 128'h0);
        send(ACT_ENCRYPT, 3'd0, 32'd0, 1'b0, {128{1'b1}});
        send(ACT_DECRYPT, 3'd0, 32'd0, 1'b0, 128'h0);
        send(ACT_DECRYPT, 3'd0, 32'd0, 1'b0, {128{1'b1}});
        send(ACT_NONE, 3'd7, 32'hffffffff, 1'b1, {128{1'b1}});
        send(ACT_ENCRYPT, 3'd0, 32'd0, 1'b0, 128'h1);
        // Single word reload without expansion, then with it.
        send(ACT_LOAD, 3'd3, 32'h12345678, 1'b0, 128'h0);
        send(ACT_ENCRYPT, 3'd0, 32'd0, 1'b0, rand_block());
        send(ACT_LOAD, 3'd0, 32'hffffffff, 1'b1, 128'h0);
        send(ACT_DECRYPT, 3'd0, 32'd0, 1'b0, rand_block());
        drain();

        masks = '{32'hffffffff, $urandom, 32'h80000001, $urandom};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_mask(masks[ph]);
            if (ph == 3) quiet_tail = 1'b1;
            for (int n = 0; n < 230; n++)
            begin
                case ($urandom_range(0, 19))
                    0: load_key(0);
                    1: send(ACT_LOAD, 3'($urandom_range(0, 7)), $urandom,
                            1'($urandom_range(0, 1)), rand_block());
                    2: send(ACT_NONE, 3'($urandom_range(0, 7)), $urandom,
                            1'($urandom_range(0, 1)), rand_block());
                    default: send($urandom_range(0, 1) ? ACT_ENCRYPT : ACT_DECRYPT,
                                  3'($urandom_range(0, 7)), $urandom,
                                  1'($urandom_range(0, 1)), rand_block());
                endcase
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("Testbench completed without errors");
        else
        begin
            if (board.pending.size() != 0)
                $error("%0d expected blocks never arrived", board.pending.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/rc6_pkg.sv
rtl/rc6_variant_block_cipher_core.sv
tb/rc6_variant_block_cipher_core_test.sv
